// ----- hw/rtl/tpcl_pkg.sv -----
// ============================================================================
// tpcl_pkg
// Shared types for the two-pass convolution layer controller.
// ============================================================================
package tpcl_pkg;

    localparam int CountWidth = 8;

    // Group 0-2 pass count that hands over to the second group.
    localparam logic [CountWidth-1:0] HandoverCount = CountWidth'(1);
    // Group 3-5 pass count that ends the layer.
    localparam logic [CountWidth-1:0] FinalCount    = CountWidth'(2);
    // Reset value of pass_limit.
    localparam logic [CountWidth-1:0] PassLimitInit = CountWidth'(1);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_IN_A   = 7'b0000010,
        ST_MAC_A  = 7'b0000100,
        ST_LB_RST = 7'b0001000,
        ST_IN_B   = 7'b0010000,
        ST_MAC_B  = 7'b0100000,
        ST_STOP   = 7'b1000000
    } state_t;

    typedef struct packed {
        logic producer_valid;
        logic window_valid;
        logic mac_finished;
        logic channel_finished;
    } tick_t;

    typedef struct packed {
        logic ready_out;
        logic pixel_accept;
        logic clear_pulse;
        logic start_pulse;
        logic second_group;
    } result_t;

endpackage

// ----- hw/rtl/tpcl_if.sv -----
// ============================================================================
// tpcl_if
// Valid/ready channels for tick requests and result requests.
// ============================================================================
interface tpcl_tick_if;
    import tpcl_pkg::*;

    logic  valid;
    logic  ready;
    tick_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tpcl_result_if;
    import tpcl_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/two_pass_conv_layer_controller_top.sv -----
// ============================================================================
// two_pass_conv_layer_controller_top
// Two-pass (channels 0-2, then 3-5) convolution layer controller.
// ============================================================================
//
//  channel   dir   payload    meaning
//  -------   ---   --------   ------------------------------------------
//  tick      in    tick_t     one clock tick of handshake flags
//  result    out   result_t   ready/accept/pulse/group flags for that tick
//  cfg       in    8 bits     pass_limit write (cfg_we, cfg_wdata)
//
//  One tick request per cycle, sustained while the result register drains. A
//  request lands in the input register; the FSM step and the result register
//  load happen together, once the result slot is free or draining.
//  rst_n clears the FSM to idle, the pulses and pass counter to 0, and
//  pass_limit to 1. A stalled result holds the input register; the tick
//  channel keeps flowing as long as the result register drains.
//
module two_pass_conv_layer_controller_top (
    input  logic                            clk,
    input  logic                            rst_n,
    tpcl_tick_if.sink                       tick,
    tpcl_result_if.source                   result,
    input  logic                            cfg_we,
    input  logic [tpcl_pkg::CountWidth-1:0] cfg_wdata
);
    import tpcl_pkg::*;

    // configuration register
    logic [CountWidth-1:0] limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= PassLimitInit;
        else if (cfg_we)
            limit_reg <= cfg_wdata;
    end

    // input register
    logic  in_valid_reg;
    tick_t in_data_reg;
    logic  step;

    // result register
    logic    out_valid_reg;
    result_t out_data_reg;
    result_t core_result;

    // step when a tick is held and the result slot is free or draining
    assign step       = in_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (tick.ready)
            in_valid_reg <= tick.valid;
    end

    always_ff @(posedge clk)
    begin
        if (tick.ready && tick.valid)
            in_data_reg <= tick.data;
    end

    tpcl_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .tick       (in_data_reg),
        .pass_limit (limit_reg),
        .result     (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_data_reg <= core_result;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

endmodule

// ----- hw/rtl/tpcl_core.sv -----
// ============================================================================
// tpcl_core
// Layer FSM, pulse registers and pass counter; advances once per step.
// ============================================================================
module tpcl_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  tpcl_pkg::tick_t                     tick,
    input  logic [tpcl_pkg::CountWidth-1:0]     pass_limit,
    output tpcl_pkg::result_t                   result
);
    import tpcl_pkg::*;

    state_t                state_reg, fsm_next;
    logic                  start_reg, start_next;
    logic                  clear_reg, clear_next;
    logic [CountWidth-1:0] count_reg, count_next;

    logic accepting;
    logic ready;
    logic accept;

    // outputs come from the state held before this step's update
    always_comb
    begin
        accepting = (state_reg == ST_IDLE) || (state_reg == ST_IN_A) ||
                    (state_reg == ST_IN_B);
        ready     = accepting && !tick.window_valid;
        accept    = ready && tick.producer_valid;

        result.ready_out    = ready;
        result.pixel_accept = accept;
        result.clear_pulse  = clear_reg;
        result.start_pulse  = start_reg;
        result.second_group = (state_reg == ST_IN_B) || (state_reg == ST_MAC_B);
    end

    always_comb
    begin
        fsm_next   = state_reg;
        start_next = start_reg;
        clear_next = clear_reg;

        case (state_reg)
            ST_IDLE:
            begin
                start_next = 1'b0;
                clear_next = 1'b0;
                if (tick.producer_valid)
                    fsm_next = ST_IN_A;
            end
            ST_IN_A:
            begin
                if (tick.window_valid)
                begin
                    start_next = 1'b1;
                    fsm_next   = ST_MAC_A;
                end
            end
            ST_MAC_A:
            begin
                start_next = 1'b0;
                if (tick.mac_finished)
                begin
                    if (count_reg == pass_limit)
                    begin
                        clear_next = 1'b1;
                        fsm_next   = ST_STOP;
                    end
                    else if (count_reg == HandoverCount)
                    begin
                        clear_next = 1'b1;
                        fsm_next   = ST_LB_RST;
                    end
                    else
                        fsm_next = ST_IN_A;
                end
            end
            ST_LB_RST:
            begin
                clear_next = 1'b0;
                fsm_next   = ST_IN_B;
            end
            ST_IN_B:
            begin
                if (tick.window_valid)
                begin
                    start_next = 1'b1;
                    fsm_next   = ST_MAC_B;
                end
            end
            ST_MAC_B:
            begin
                start_next = 1'b0;
                if (tick.mac_finished)
                begin
                    if (count_reg == FinalCount)
                    begin
                        clear_next = 1'b1;
                        fsm_next   = ST_STOP;
                    end
                    else
                        fsm_next = ST_IN_B;
                end
            end
            ST_STOP:
            begin
                clear_next = 1'b0;
                fsm_next   = ST_IDLE;
            end
            default:
            begin
                // illegal code: pulses hold, recover to idle
                fsm_next = ST_IDLE;
            end
        endcase

        if (state_reg == ST_STOP)
            count_next = '0;
        else if (tick.channel_finished && accept)
            count_next = count_reg + CountWidth'(1);
        else
            count_next = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            start_reg <= 1'b0;
            clear_reg <= 1'b0;
            count_reg <= '0;
        end
        else if (step)
        begin
            state_reg <= fsm_next;
            start_reg <= start_next;
            clear_reg <= clear_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the two-pass convolution layer controller.
// Tick requests are sent on the valid/ready channel, each one is run through
// a cycle-accurate model of the FSM, and every result request is checked
// field by field, in order, against the expected flags.
// ============================================================================
module tb_top;
    import tpcl_pkg::*;

    localparam int StallLimit = 1000;   // cycles with no handshake before giving up

    // Directed walk through both channel groups, encoded {pv, wv, md, cd}.
    // Meant to run with pass_limit = 2, starting right after reset.
    localparam logic [3:0] DirectedSeq [21] = '{
        4'b0000,    // idle, nothing happens
        4'b1111,    // idle with window valid: not ready, but still leaves idle
        4'b1001,    // group 0-2 pixel with channel done, count 1
        4'b0100,    // window valid, MAC start
        4'b0000,    // wait for MAC
        4'b0011,    // MAC done at count 1 -> line buffer reset, clear pulse
        4'b1111,    // line buffer reset -> group 3-5
        4'b1001,    // group 3-5 pixel, count 2
        4'b1100,    // window valid, MAC start, not accepted
        4'b0010,    // MAC done at count 2 -> stop
        4'b1111,    // stop clears the counter, back to idle
        4'b1001,    // pixel accepted while idle, count 1
        4'b1001,    // count 2
        4'b0100,    // MAC start
        4'b0010,    // count equals pass_limit -> straight to stop
        4'b0000,    // stop -> idle
        4'b1000,    // pixel without channel done
        4'b0100,    // MAC start
        4'b0010,    // count 0: neither limit nor handover, back to image in
        4'b1101,    // window valid blocks the pixel, MAC start
        4'b0010     // back to image in
    };

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the result of each accepted tick and checks the
    // result stream against it in order.
    // ------------------------------------------------------------------------
    class conv_ctrl_scoreboard;
        state_t                state;
        logic                  start_r;
        logic                  clear_r;
        logic [CountWidth-1:0] count;
        logic [CountWidth-1:0] limit;
        result_t               expected_q[$];
        int                    errors;
        int                    checked;
        int                    wraps;
        int                    second_groups;
        int                    layers_done;

        function new();
            state         = ST_IDLE;
            start_r       = 1'b0;
            clear_r       = 1'b0;
            count         = '0;
            limit         = PassLimitInit;
            errors        = 0;
            checked       = 0;
            wraps         = 0;
            second_groups = 0;
            layers_done   = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // One accepted tick: push the flags it produces, then step the FSM.
        function void note_tick(tick_t t);
            result_t r;
            state_t  nxt;
            logic    nstart;
            logic    nclear;
            logic    accepting;

            accepting      = (state == ST_IDLE) || (state == ST_IN_A) || (state == ST_IN_B);
            r.ready_out    = accepting && !t.window_valid;
            r.pixel_accept = t.producer_valid && r.ready_out;
            r.clear_pulse  = clear_r;
            r.start_pulse  = start_r;
            r.second_group = (state == ST_IN_B) || (state == ST_MAC_B);
            expected_q.push_back(r);

            nxt    = state;
            nstart = start_r;
            nclear = clear_r;
            case (state)
                ST_IDLE:
                begin
                    nstart = 1'b0;
                    nclear = 1'b0;
                    if (t.producer_valid)
                        nxt = ST_IN_A;
                end
                ST_IN_A:
                begin
                    if (t.window_valid)
                    begin
                        nstart = 1'b1;
                        nxt    = ST_MAC_A;
                    end
                end
                ST_MAC_A:
                begin
                    nstart = 1'b0;
                    if (t.mac_finished)
                    begin
                        if (count == limit)
                        begin
                            nclear = 1'b1;
                            nxt    = ST_STOP;
                        end
                        else if (count == HandoverCount)
                        begin
                            nclear = 1'b1;
                            nxt    = ST_LB_RST;
                        end
                        else
                            nxt = ST_IN_A;
                    end
                end
                ST_LB_RST:
                begin
                    nclear = 1'b0;
                    nxt    = ST_IN_B;
                    second_groups++;
                end
                ST_IN_B:
                begin
                    if (t.window_valid)
                    begin
                        nstart = 1'b1;
                        nxt    = ST_MAC_B;
                    end
                end
                ST_MAC_B:
                begin
                    nstart = 1'b0;
                    if (t.mac_finished)
                    begin
                        if (count == FinalCount)
                        begin
                            nclear = 1'b1;
                            nxt    = ST_STOP;
                        end
                        else
                            nxt = ST_IN_B;
                    end
                end
                ST_STOP:
                begin
                    nclear = 1'b0;
                    nxt    = ST_IDLE;
                    layers_done++;
                end
                default:
                    nxt = ST_IDLE;
            endcase

            if (state == ST_STOP)
                count = '0;
            else if (t.channel_finished && r.pixel_accept)
            begin
                if (count == '1)
                    wraps++;
                count = count + CountWidth'(1);
            end

            state   = nxt;
            start_r = nstart;
            clear_r = nclear;
        endfunction

        task report_mismatch(string what);
            if (errors < 50)
                $display("MISMATCH @%0t result #%0d %s", $time, checked, what);
            errors++;
        endtask

        task check_result(result_t got);
            result_t exp;

            if (expected_q.size() == 0)
                report_mismatch($sformatf("unexpected result %b", got));
            else
            begin
                exp = expected_q.pop_front();
                if (got.ready_out !== exp.ready_out)
                    report_mismatch($sformatf("ready_out: got %b, expected %b",
                                              got.ready_out, exp.ready_out));
                if (got.pixel_accept !== exp.pixel_accept)
                    report_mismatch($sformatf("pixel_accept: got %b, expected %b",
                                              got.pixel_accept, exp.pixel_accept));
                if (got.clear_pulse !== exp.clear_pulse)
                    report_mismatch($sformatf("clear_pulse: got %b, expected %b",
                                              got.clear_pulse, exp.clear_pulse));
                if (got.start_pulse !== exp.start_pulse)
                    report_mismatch($sformatf("start_pulse: got %b, expected %b",
                                              got.start_pulse, exp.start_pulse));
                if (got.second_group !== exp.second_group)
                    report_mismatch($sformatf("second_group: got %b, expected %b",
                                              got.second_group, exp.second_group));
                checked++;
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CountWidth-1:0] cfg_wdata;

    tpcl_tick_if   tick_ch ();
    tpcl_result_if result_ch ();

    two_pass_conv_layer_controller_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    conv_ctrl_scoreboard sb;

    int tick_gap_pct;       // chance of a gap before a tick request
    int result_stall_pct;   // chance of a stall burst on result ready
    int ticks_sent;
    int cfg_writes;
    int quiet_cycles;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Result side: ready is high except for random stall bursts.
    initial
    begin
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (result_stall_pct != 0 && $urandom_range(1, 100) <= result_stall_pct)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Every result request is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_result(result_ch.data);
    end

    // Watchdog: a run of cycles with no handshake on either channel is a hang.
    always @(posedge clk)
    begin
        if (!rst_n || (tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit)
        begin
            $display("Timeout: no handshake for %0d cycles", StallLimit);
            $display("FAIL two_pass_conv_layer_controller_top");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drive helpers
    // ------------------------------------------------------------------------
    function automatic bit chance(int pct);
        return $urandom_range(1, 100) <= pct;
    endfunction

    // Send one tick request, with an optional gap first; the model is stepped
    // at the edge where the request is taken.
    task automatic drive_tick(input tick_t t);
        if (tick_gap_pct != 0 && chance(tick_gap_pct))
        begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.data  <= t;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
        sb.note_tick(t);
        ticks_sent++;
    endtask

    // Tick flags biased by the predicted state so that layers actually move
    // through both channel groups and finish; the other flags stay random.
    function automatic tick_t shaped_tick();
        tick_t t;

        t = tick_t'(4'($urandom_range(0, 15)));
        case (sb.state)
            ST_IDLE:
                t.producer_valid = chance(80);
            ST_IN_A:
            begin
                t.producer_valid   = chance(75);
                t.window_valid     = chance(25);
                t.channel_finished = chance(sb.count == '0 ? 60 : 15);
            end
            ST_IN_B:
            begin
                t.producer_valid   = chance(75);
                t.window_valid     = chance(25);
                t.channel_finished = chance(sb.count < FinalCount ? 60 : 10);
            end
            ST_MAC_A, ST_MAC_B:
                t.mac_finished = chance(45);
            default:
                ;
        endcase
        return t;
    endfunction

    // Mostly shaped traffic, with some fully random noise mixed in.
    task automatic run_layers(input int n);
        for (int i = 0; i < n; i++)
        begin
            if (chance(15))
                drive_tick(tick_t'(4'($urandom_range(0, 15))));
            else
                drive_tick(shaped_tick());
        end
    endtask

    // Hold an image-in state with a channel-done pixel every tick so the
    // pass counter runs past 255 and wraps.
    task automatic run_counter_wrap(input int n);
        tick_t t;

        while (!(sb.state == ST_IN_A || sb.state == ST_IN_B))
            drive_tick(shaped_tick());
        for (int i = 0; i < n; i++)
        begin
            t                  = '0;
            t.producer_valid   = 1'b1;
            t.channel_finished = 1'b1;
            t.mac_finished     = 1'($urandom_range(0, 1));
            drive_tick(t);
        end
    endtask

    // Stop sending and let every outstanding result come back before the
    // register is touched.
    task automatic drain();
        tick_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_pass_limit(input logic [CountWidth-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.limit  = v;
        cfg_writes++;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb               = new();
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        tick_ch.valid    = 1'b0;
        tick_ch.data     = '0;
        tick_gap_pct     = 0;
        result_stall_pct = 0;
        ticks_sent       = 0;
        cfg_writes       = 0;
        quiet_cycles     = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk: handover at count 1, stop at count 2, limit stop.
        write_pass_limit(CountWidth'(2));
        foreach (DirectedSeq[i])
            drive_tick(tick_t'(DirectedSeq[i]));
        drain();

        // Reset-value limit: the first group ends the layer at count 1.
        write_pass_limit(PassLimitInit);
        tick_gap_pct     = 25;
        result_stall_pct = 25;
        run_layers(200);
        drain();

        // Limit 0: a MAC done with an empty counter stops the layer.
        write_pass_limit('0);
        tick_gap_pct     = 0;
        result_stall_pct = 30;
        run_layers(200);
        drain();

        // Limit at the top of the range, plus a counter wrap.
        write_pass_limit('1);
        tick_gap_pct     = 20;
        result_stall_pct = 20;
        run_counter_wrap(260);
        run_layers(150);
        drain();

        write_pass_limit(CountWidth'(3));
        tick_gap_pct     = 30;
        result_stall_pct = 0;
        run_layers(200);
        drain();

        // Last stretch at full rate on both sides.
        write_pass_limit(CountWidth'($urandom_range(0, 255)));
        tick_gap_pct     = 0;
        result_stall_pct = 0;
        run_layers(150);

        tick_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Covered %0d tick requests and %0d checked results over %0d pass_limit writes",
                 ticks_sent, sb.checked, cfg_writes);
        $display("Layers done: %0d, entries into channels 3-5: %0d, counter wraps: %0d",
                 sb.layers_done, sb.second_groups, sb.wraps);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS two_pass_conv_layer_controller_top");
        else
            $display("FAIL two_pass_conv_layer_controller_top");
        $finish;
    end

endmodule
